[src/maes_pkg.sv]
`default_nettype none

package maes_pkg;

    // Basic data types: one nibble and one 16-bit block of four nibbles.
    typedef logic [3:0]  nibble_t;
    typedef logic [15:0] block_t;

    // Configuration port geometry and register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

    localparam cfg_index_t CFG_CIPHER_KEY   = 2'd0;
    localparam cfg_index_t CFG_ROUND_COUNT  = 2'd1;
    localparam cfg_index_t CFG_DECRYPT_MODE = 2'd2;

    // Key schedule step constants.
    localparam nibble_t RCON_0 = 4'h1;
    localparam nibble_t RCON_1 = 4'h2;

    // Field polynomial x^4+x+1 without the x^4 term.
    localparam nibble_t GF_POLY_LOW = 4'h3;

    // Forward substitution box.
    function automatic nibble_t sbox(input nibble_t x);
        nibble_t y;
        case (x)
            4'h0: y = 4'hE;
            4'h1: y = 4'h4;
            4'h2: y = 4'hD;
            4'h3: y = 4'h1;
            4'h4: y = 4'h2;
            4'h5: y = 4'hF;
            4'h6: y = 4'hB;
            4'h7: y = 4'h8;
            4'h8: y = 4'h3;
            4'h9: y = 4'hA;
            4'hA: y = 4'h6;
            4'hB: y = 4'hC;
            4'hC: y = 4'h5;
            4'hD: y = 4'h9;
            4'hE: y = 4'h0;
            default: y = 4'h7;
        endcase
        return y;
    endfunction

    // Inverse substitution box.
    function automatic nibble_t inv_sbox(input nibble_t x);
        nibble_t y;
        case (x)
            4'h0: y = 4'hE;
            4'h1: y = 4'h3;
            4'h2: y = 4'h4;
            4'h3: y = 4'h8;
            4'h4: y = 4'h1;
            4'h5: y = 4'hC;
            4'h6: y = 4'hA;
            4'h7: y = 4'hF;
            4'h8: y = 4'h7;
            4'h9: y = 4'hD;
            4'hA: y = 4'h9;
            4'hB: y = 4'h6;
            4'hC: y = 4'hB;
            4'hD: y = 4'h2;
            4'hE: y = 4'h0;
            default: y = 4'h5;
        endcase
        return y;
    endfunction

    // Multiply by x in GF(16), reducing by the field polynomial.
    function automatic nibble_t gf_mul2(input nibble_t b);
        nibble_t r;
        r = {b[2:0], 1'b0};
        if (b[3])
        begin
            r = r ^ GF_POLY_LOW;
        end
        return r;
    endfunction

    function automatic nibble_t gf_mul3(input nibble_t b);
        return gf_mul2(b) ^ b;
    endfunction

    // Column mixing with [[3,2],[2,3]]; the matrix is its own inverse.
    function automatic block_t mix_columns(input block_t d);
        nibble_t a0;
        nibble_t a1;
        nibble_t a2;
        nibble_t a3;
        a0 = d[15:12];
        a1 = d[11:8];
        a2 = d[7:4];
        a3 = d[3:0];
        return {gf_mul3(a0) ^ gf_mul2(a1), gf_mul2(a0) ^ gf_mul3(a1),
                gf_mul3(a2) ^ gf_mul2(a3), gf_mul2(a2) ^ gf_mul3(a3)};
    endfunction

    // Exchange nibbles 1 and 3.
    function automatic block_t swap13(input block_t d);
        return {d[15:12], d[3:0], d[7:4], d[11:8]};
    endfunction

    // One key schedule step from the previous round key.
    function automatic block_t next_round_key(input block_t k, input nibble_t rc);
        nibble_t n0;
        nibble_t n1;
        nibble_t n2;
        nibble_t n3;
        n0 = k[15:12] ^ sbox(k[3:0]) ^ rc;
        n1 = k[11:8] ^ n0;
        n2 = k[7:4] ^ n1;
        n3 = k[3:0] ^ n2;
        return {n0, n1, n2, n3};
    endfunction

endpackage

`default_nettype wire

[src/maes_round.sv]
`default_nettype none

module maes_round
(
    input  wire maes_pkg::block_t data_in,
    input  wire maes_pkg::block_t round_key,
    input  wire                   decrypt,
    input  wire                   enable,
    output maes_pkg::block_t      data_out
);
    import maes_pkg::*;

    block_t enc_sub;
    block_t enc_result;
    block_t dec_swap;
    block_t dec_result;

    // Encryption: key addition, substitution, nibble swap, column mix.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            enc_sub[4*i +: 4] = sbox(data_in[4*i +: 4] ^ round_key[4*i +: 4]);
        end
        enc_result = mix_columns(swap13(enc_sub));
    end

    // Decryption: the same steps undone in reverse order.
    always_comb
    begin
        dec_swap = swap13(mix_columns(data_in));
        for (int i = 0; i < 4; i++)
        begin
            dec_result[4*i +: 4] = inv_sbox(dec_swap[4*i +: 4]) ^ round_key[4*i +: 4];
        end
    end

    // A stage beyond the configured round count passes the block through; otherwise decrypt picks the result.
    always_comb
    begin
        if (!enable)
        begin
            data_out = data_in;
        end
        else if (decrypt)
        begin
            data_out = dec_result;
        end
        else
        begin
            data_out = enc_result;
        end
    end

endmodule

`default_nettype wire

[src/mini_aes_block_cipher_unit.sv]
// A block accepted with start is taken into the input register, passes the three
// unrolled rounds and appears on block_out with done high from the result register.
// Throughput: one block per cycle; busy stays low, since the three unrolled rounds
// sit between the input register and the result register.
// Reset clears the configuration to key 0, one round, encrypt, and drops done.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module mini_aes_block_cipher_unit
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     start,
    output logic                    busy,
    input  wire maes_pkg::block_t   block_in,
    output logic                    done,
    output maes_pkg::block_t        block_out,
    input  wire                     cfg_write_en,
    input  wire maes_pkg::cfg_index_t cfg_index,
    input  wire maes_pkg::cfg_data_t  cfg_wdata
);
    import maes_pkg::*;

    block_t      cipher_key_reg;
    logic [1:0]  round_count_reg;
    logic        decrypt_mode_reg;

    block_t      in_reg;
    logic        in_valid_reg;
    block_t      out_reg;
    logic        done_reg;

    block_t      key0;
    block_t      key1;
    block_t      key2;
    block_t      stage_key [3];
    logic        stage_en  [3];
    block_t      stage_data [4];

    // The block never refuses an item.
    assign busy = 1'b0;

    // Configuration registers; writes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cipher_key_reg   <= '0;
            round_count_reg  <= 2'd1;
            decrypt_mode_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_CIPHER_KEY:   cipher_key_reg   <= cfg_wdata[15:0];
                CFG_ROUND_COUNT:  round_count_reg  <= cfg_wdata[1:0];
                CFG_DECRYPT_MODE: decrypt_mode_reg <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    // Key schedule from the configured key.
    assign key0 = cipher_key_reg;
    assign key1 = next_round_key(key0, RCON_0);
    assign key2 = next_round_key(key1, RCON_1);

    // Round key and enable per stage. Decryption takes the keys last to first.
    always_comb
    begin
        stage_en[0] = (round_count_reg > 2'd0);
        stage_en[1] = (round_count_reg > 2'd1);
        stage_en[2] = (round_count_reg > 2'd2);
        if (!decrypt_mode_reg)
        begin
            stage_key[0] = key0;
            stage_key[1] = key1;
            stage_key[2] = key2;
        end
        else
        begin
            case (round_count_reg)
                2'd3:
                begin
                    stage_key[0] = key2;
                    stage_key[1] = key1;
                    stage_key[2] = key0;
                end
                2'd2:
                begin
                    stage_key[0] = key1;
                    stage_key[1] = key0;
                    stage_key[2] = key0;
                end
                default:
                begin
                    stage_key[0] = key0;
                    stage_key[1] = key0;
                    stage_key[2] = key0;
                end
            endcase
        end
    end

    // Three round stages between the input and result registers.
    assign stage_data[0] = in_reg;

    for (genvar g = 0; g < 3; g++)
    begin : g_round
        maes_round u_round
        (
            .data_in   (stage_data[g]),
            .round_key (stage_key[g]),
            .decrypt   (decrypt_mode_reg),
            .enable    (stage_en[g]),
            .data_out  (stage_data[g+1])
        );
    end

    // Input register and result register with its one-cycle strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start;
            done_reg     <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            in_reg <= block_in;
        end
        if (in_valid_reg)
        begin
            out_reg <= stage_data[3];
        end
    end

    assign done      = done_reg;
    assign block_out = out_reg;

endmodule

`default_nettype wire

[tb/mini_aes_block_cipher_checker.sv]
`timescale 1ns / 1ps

module mini_aes_block_cipher_checker
(
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       start,
    input  wire                       busy,
    input  wire maes_pkg::block_t     block_in,
    input  wire                       done,
    input  wire maes_pkg::block_t     block_out,
    input  wire                       cfg_write_en,
    input  wire maes_pkg::cfg_index_t cfg_index,
    input  wire maes_pkg::cfg_data_t  cfg_wdata,
    input  wire                       run_done,
    output int                        mismatches,
    output int                        pending
);

    import maes_pkg::*;

    // Reduction polynomial x^4+x+1 with the carry bit.
    localparam logic [4:0] FIELD_POLY = 5'h13;

    localparam nibble_t SUB_FWD [16] = '{
        4'hE, 4'h4, 4'hD, 4'h1, 4'h2, 4'hF, 4'hB, 4'h8,
        4'h3, 4'hA, 4'h6, 4'hC, 4'h5, 4'h9, 4'h0, 4'h7
    };

    localparam nibble_t SUB_INV [16] = '{
        4'hE, 4'h3, 4'h4, 4'h8, 4'h1, 4'hC, 4'hA, 4'hF,
        4'h7, 4'hD, 4'h9, 4'h6, 4'hB, 4'h2, 4'h0, 4'h5
    };

    typedef struct packed {
        block_t source;
        block_t result;
    } block_job_t;

    // Blocks accepted by the unit whose output has not come out yet.
    block_job_t cipher_results_due [$];

    // Shadow copy of the configuration registers.
    block_t     key_reg;
    logic [1:0] rounds_reg;
    logic       decrypt_reg;

    int mismatch_total = 0;
    int due_count = 0;

    assign mismatches = mismatch_total;
    assign pending    = due_count;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_total++;
    endtask

    // Multiply a nibble by x in GF(16).
    function automatic nibble_t times_x(input nibble_t b);
        logic [4:0] w;
        w = {b, 1'b0};
        if (w[4])
        begin
            w = w ^ FIELD_POLY;
        end
        return w[3:0];
    endfunction

    // Columns (n0,n1) and (n2,n3) times [[3,2],[2,3]], where 3*b = x*b + b.
    function automatic block_t mix_block(input block_t d);
        nibble_t a0;
        nibble_t a1;
        nibble_t a2;
        nibble_t a3;
        a0 = d[15:12];
        a1 = d[11:8];
        a2 = d[7:4];
        a3 = d[3:0];
        return {times_x(a0) ^ a0 ^ times_x(a1), times_x(a0) ^ times_x(a1) ^ a1,
                times_x(a2) ^ a2 ^ times_x(a3), times_x(a2) ^ times_x(a3) ^ a3};
    endfunction

    function automatic block_t swap_inner(input block_t d);
        return {d[15:12], d[3:0], d[7:4], d[11:8]};
    endfunction

    // Each nibble goes through the forward or the inverse substitution.
    function automatic block_t sub_block(input block_t d, input logic inverse);
        block_t y;
        int     i;
        for (i = 0; i < 4; i++)
        begin
            y[4*i +: 4] = inverse ? SUB_INV[d[4*i +: 4]] : SUB_FWD[d[4*i +: 4]];
        end
        return y;
    endfunction

    // Derive the next round key from the previous one.
    function automatic block_t key_step(input block_t k, input nibble_t rc);
        nibble_t n0;
        nibble_t n1;
        nibble_t n2;
        nibble_t n3;
        n0 = k[15:12] ^ SUB_FWD[k[3:0]] ^ rc;
        n1 = k[11:8] ^ n0;
        n2 = k[7:4] ^ n1;
        n3 = k[3:0] ^ n2;
        return {n0, n1, n2, n3};
    endfunction

    // Full encryption or decryption of one block under the given settings.
    function automatic block_t cipher_block(input block_t blk, input block_t key,
                                            input logic [1:0] rounds, input logic decrypt);
        block_t round_keys [3];
        block_t d;
        int     r;
        round_keys[0] = key;
        round_keys[1] = key_step(round_keys[0], RCON_0);
        round_keys[2] = key_step(round_keys[1], RCON_1);
        d = blk;
        if (decrypt)
        begin
            for (r = int'(rounds); r > 0; r--)
            begin
                d = sub_block(swap_inner(mix_block(d)), 1'b1) ^ round_keys[r-1];
            end
        end
        else
        begin
            for (r = 0; r < int'(rounds); r++)
            begin
                d = mix_block(swap_inner(sub_block(d ^ round_keys[r], 1'b0)));
            end
        end
        return d;
    endfunction

    // Watch the result strobe, the accepted items and the register writes.
    always @(posedge clk or negedge rst_n)
    begin : watch
        block_job_t job;
        if (!rst_n)
        begin
            key_reg     = '0;
            rounds_reg  = 2'd1;
            decrypt_reg = 1'b0;
            cipher_results_due.delete();
            due_count   = 0;
        end
        else
        begin
            // Compare an output block with the oldest block still due.
            if (done)
            begin
                if (cipher_results_due.size() == 0)
                begin
                    report_mismatch($sformatf("block_out %h with no item outstanding",
                                              block_out));
                end
                else
                begin
                    job = cipher_results_due.pop_front();
                    if (block_out !== job.result)
                    begin
                        report_mismatch($sformatf("block_out %h, want %h for block_in %h",
                                                  block_out, job.result, job.source));
                    end
                end
            end

            // Predict the output of a newly accepted item.
            if (start && !busy)
            begin
                job.source = block_in;
                job.result = cipher_block(block_in, key_reg, rounds_reg, decrypt_reg);
                cipher_results_due.push_back(job);
            end

            // Track register writes; an unknown index changes nothing.
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_CIPHER_KEY:   key_reg     = cfg_wdata;
                    CFG_ROUND_COUNT:  rounds_reg  = cfg_wdata[1:0];
                    CFG_DECRYPT_MODE: decrypt_reg = cfg_wdata[0];
                    default:          ;
                endcase
            end

            due_count = cipher_results_due.size();
        end
    end

    // Any block still due when the run ends never came out.
    always @(posedge run_done)
    begin
        if (cipher_results_due.size() != 0)
        begin
            report_mismatch($sformatf("%0d item(s) produced no block_out",
                                      cipher_results_due.size()));
        end
    end

endmodule

[tb/tb_mini_aes_block_cipher_unit.sv]
`timescale 1ns / 1ps

module tb_mini_aes_block_cipher_unit;

    import maes_pkg::*;

    // Index past the three registers; writes to it must be ignored.
    localparam cfg_index_t CFG_UNUSED_INDEX = 2'd3;

    localparam int RANDOM_PHASES = 13;
    localparam int PHASE_BLOCKS  = 100;
    localparam int MAX_GAP       = 6;
    localparam int DRAIN_CYCLES  = 4;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    block_t     block_in = '0;
    logic       cfg_write_en = 1'b0;
    cfg_index_t cfg_index = CFG_CIPHER_KEY;
    cfg_data_t  cfg_wdata = '0;
    logic       run_done = 1'b0;

    logic       busy;
    logic       done;
    block_t     block_out;
    int         mismatches;
    int         pending;

    mini_aes_block_cipher_unit DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .block_in     (block_in),
        .done         (done),
        .block_out    (block_out),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    mini_aes_block_cipher_checker cipher_monitor
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .block_in     (block_in),
        .done         (done),
        .block_out    (block_out),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .run_done     (run_done),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    always #5 clk = ~clk;

    // Hard stop in case the unit hangs.
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // Offer one item after an optional idle gap and hold it until it is taken.
    task automatic send_block(input block_t blk, input int gap);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start    <= 1'b1;
        block_in <= blk;
        do
        begin
            @(posedge clk);
        end
        while (busy);
    endtask

    task automatic write_reg(input cfg_index_t idx, input cfg_data_t data);
        @(negedge clk);
        start        <= 1'b0;
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_wdata    <= data;
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic load_config(input cfg_data_t key, input cfg_data_t rounds_word,
                               input cfg_data_t mode_word);
        write_reg(CFG_CIPHER_KEY, key);
        write_reg(CFG_ROUND_COUNT, rounds_word);
        write_reg(CFG_DECRYPT_MODE, mode_word);
    endtask

    // Stop offering items and wait until every block has come out.
    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin : stimulus
        int         p;
        int         i;
        int         gap;
        logic       burst;
        logic [1:0] rounds;
        logic       mode_bit;
        cfg_data_t  key_word;
        cfg_data_t  rounds_word;
        cfg_data_t  mode_word;
        block_t     blk;

        burst = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: zero key, one round, encrypt.
        send_block(16'h0000, $urandom_range(0, MAX_GAP));
        send_block(16'hFFFF, $urandom_range(0, MAX_GAP));
        send_block(16'h1234, 0);
        settle();

        // Zero round count passes the block through in both modes.
        write_reg(CFG_ROUND_COUNT, 16'h0000);
        send_block(16'hA5C3, 0);
        send_block(16'hFFFF, $urandom_range(0, MAX_GAP));
        settle();
        write_reg(CFG_DECRYPT_MODE, 16'h0001);
        send_block(16'h0000, 0);
        send_block(16'h5A3C, $urandom_range(0, MAX_GAP));
        settle();

        // Upper data bits must be dropped; the unused index changes nothing.
        load_config(16'hFFFF, 16'hFFFF, 16'hFFFE);
        write_reg(CFG_UNUSED_INDEX, 16'hFFFF);
        send_block(16'h0000, 0);
        send_block(16'hFFFF, 0);
        send_block(16'h8421, $urandom_range(0, MAX_GAP));
        settle();
        write_reg(CFG_ROUND_COUNT, 16'hFFFE);
        write_reg(CFG_DECRYPT_MODE, 16'h0001);
        send_block(16'h0000, $urandom_range(0, MAX_GAP));
        send_block(16'hFFFF, 0);
        send_block(16'h1248, 0);
        settle();
        write_reg(CFG_CIPHER_KEY, 16'h8001);
        write_reg(CFG_ROUND_COUNT, 16'h0003);
        send_block(16'h7FFE, 0);
        settle();

        // Random phases sweep key extremes, every round count and both modes.
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            rounds   = 2'(p % 4);
            mode_bit = 1'((p / 4) % 2);
            case (p % 5)
                0:       key_word = 16'h0000;
                1:       key_word = 16'hFFFF;
                default: key_word = cfg_data_t'($urandom);
            endcase
            rounds_word = cfg_data_t'($urandom_range(0, 16'h3FFF) << 2) | cfg_data_t'(rounds);
            mode_word   = cfg_data_t'($urandom_range(0, 16'h7FFF) << 1) | cfg_data_t'(mode_bit);
            load_config(key_word, rounds_word, mode_word);
            if ($urandom_range(0, 1) == 1)
            begin
                write_reg(CFG_UNUSED_INDEX, cfg_data_t'($urandom));
            end

            for (i = 0; i < PHASE_BLOCKS; i++)
            begin
                // Alternate stretches of back-to-back items with gappy ones.
                if (i % 25 == 0)
                begin
                    burst = ($urandom_range(0, 2) == 0);
                end
                gap = burst ? 0 : $urandom_range(0, MAX_GAP);
                case ($urandom_range(0, 19))
                    0:       blk = 16'h0000;
                    1:       blk = 16'hFFFF;
                    default: blk = block_t'($urandom);
                endcase
                send_block(blk, gap);
            end
            settle();
        end

        // Let the pipeline empty, then give the verdict.
        repeat (DRAIN_CYCLES) @(negedge clk);
        run_done <= 1'b1;
        @(negedge clk);
        if (mismatches == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[mini_aes_block_cipher_unit.f]
src/maes_pkg.sv
src/maes_round.sv
src/mini_aes_block_cipher_unit.sv
tb/mini_aes_block_cipher_checker.sv
tb/tb_mini_aes_block_cipher_unit.sv
